FILE: design/ekvt_pkg.sv
`timescale 1ns / 1ps

package ekvt_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int TIME_BITS   = 32;
   localparam int LIFE_BITS   = 16;
   localparam int COUNT_BITS  = 5;
   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS    = IDX_BITS + 1;

   typedef logic [1:0]            action_type;
   typedef logic [1:0]            status_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [LIFE_BITS-1:0]  life_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_GET    = 2'd1;
   localparam action_type ACT_REMOVE = 2'd2;
   localparam action_type ACT_TICK   = 2'd3;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_PRESENT = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_MISS    = 2'd3;

   localparam life_type  LIFETIME_RESET = 16'd10;
   localparam time_type  TICK_STEP      = 32'd1;
   localparam count_type COUNT_MAX      = '1;

   typedef struct packed {
      key_type   key;
      value_type value;
      time_type  deadline;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic key_eq;
      logic expired;
   } cmp_out_type;

endpackage

FILE: design/ekvt_if.sv
`timescale 1ns / 1ps

interface ekvt_req_if;
   logic                  valid;
   logic                  ready;
   ekvt_pkg::action_type  action;
   ekvt_pkg::key_type     key;
   ekvt_pkg::value_type   value;

   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

interface ekvt_rsp_if;
   logic                  valid;
   logic                  ready;
   ekvt_pkg::status_type  status;
   logic                  found;
   ekvt_pkg::value_type   read_value;
   ekvt_pkg::count_type   expired_count;

   modport source (output valid, status, found, read_value, expired_count, input ready);
   modport sink   (input valid, status, found, read_value, expired_count, output ready);
endinterface

FILE: design/expiring_key_value_table.sv
`timescale 1ns / 1ps

// Expiring key/value table. Holds ENTRIES key/value pairs, each with a deadline
// of time_now plus lifetime_ticks taken at insert. Transactions on req_ch carry
// an action (insert, get, remove, tick); every transaction yields exactly one
// transaction on rsp_ch. Insert fills the lowest free slot, reports a present
// key or a full table; get returns the value and found flag; remove drops the
// matching entry; tick advances time by one and then drops every entry whose
// deadline is strictly passed (modulo 2^32), returning how many went.
// A transaction occupies the block from acceptance until req_ch.ready returns:
// accept, a scan of the single-read-port entry RAM (one entry per cycle through
// one shared compare unit), RAM latency, then a finish step that makes the
// update and loads the result into the output register. A result waiting on
// rsp_ch holds that finish step and so blocks the next acceptance as well as
// the next result. lifetime_ticks resets to 10; the user is to write it through
// csr_wr_en/csr_wr_data only while the block is idle, which the block does not
// enforce. The table is empty after reset; no clearing pass.
module expiring_key_value_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  ekvt_pkg::life_type   csr_wr_data,
   ekvt_req_if.sink             req_ch,
   ekvt_rsp_if.source           rsp_ch
);
   import ekvt_pkg::*;

   // sequencer codes
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   cnt_type           cnt_ff, cnt_in;          // next RAM address to issue
   logic              rd_vld_ff, rd_vld_in;    // RAM output holds an entry
   idx_type           rd_idx_ff, rd_idx_in;    // slot number of that entry
   action_type        act_ff, act_in;
   key_type           key_ff, key_in;
   value_type         val_ff, val_in;
   time_type          time_now_ff, time_now_in;
   life_type          lifetime_ff, lifetime_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic              hit_ff, hit_in;
   idx_type           hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   idx_type           free_idx_ff, free_idx_in;
   value_type         rd_value_ff, rd_value_in;
   count_type         count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_found_ff, rsp_found_in;
   value_type         rsp_value_ff, rsp_value_in;
   count_type         rsp_count_ff, rsp_count_in;

   logic              req_fire;
   logic              fin_go;
   logic              ent_live;
   entry_type         ram_rd_data;
   entry_type         ram_wr_data;
   logic              ram_wr_en;
   cmp_out_type       cmp;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   // the update and the result go together, only once the output slot is free
   assign fin_go = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // entry store: key, value and deadline per slot, one read per cycle
   assign ram_wr_en = fin_go && (act_ff == ACT_INSERT) && !hit_ff && free_ff;
   always_comb begin
      ram_wr_data.key      = key_ff;
      ram_wr_data.value    = val_ff;
      ram_wr_data.deadline = time_now_ff + time_type'(lifetime_ff);
   end

   ekvt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (cnt_ff[IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   ekvt_cmp u_cmp (
      .key_a    (key_ff),
      .key_b    (ram_rd_data.key),
      .time_now (time_now_ff),
      .deadline (ram_rd_data.deadline),
      .result   (cmp)
   );

   assign ent_live = valid_ff[rd_idx_ff];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      time_now_in   = time_now_ff;
      lifetime_in   = lifetime_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rd_value_in   = rd_value_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_wr_en) begin
         lifetime_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_ch.action;
               key_in   = req_ch.key;
               val_in   = req_ch.value;
               cnt_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               count_in = '0;
               // time moves before the expiry scan of a tick
               if (req_ch.action == ACT_TICK) begin
                  time_now_in = time_now_ff + TICK_STEP;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue the next read
            if (cnt_ff != cnt_type'(ENTRIES)) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_BITS-1:0];
               cnt_in    = cnt_ff + cnt_type'(1);
            end
            // check the entry that the RAM returns now
            if (rd_vld_ff) begin
               if (ent_live && cmp.key_eq && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  rd_value_in = ram_rd_data.value;
               end
               if (!ent_live && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if ((act_ff == ACT_TICK) && ent_live && cmp.expired) begin
                  valid_in[rd_idx_ff] = 1'b0;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + count_type'(1);
                  end
               end
               if (cnt_ff == cnt_type'(ENTRIES)) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (fin_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_found_in  = 1'b0;
               rsp_value_in  = '0;
               rsp_count_in  = '0;
               case (act_ff)
                  ACT_INSERT: begin
                     if (hit_ff) begin
                        rsp_status_in = ST_PRESENT;
                     end else if (!free_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        valid_in[free_idx_ff] = 1'b1;
                     end
                  end
                  ACT_GET: begin
                     if (hit_ff) begin
                        rsp_found_in = 1'b1;
                        rsp_value_in = rd_value_ff;
                     end else begin
                        rsp_status_in = ST_MISS;
                     end
                  end
                  ACT_REMOVE: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end else begin
                        rsp_status_in = ST_MISS;
                     end
                  end
                  default: begin
                     rsp_count_in = count_ff;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         time_now_ff  <= '0;
         lifetime_ff  <= LIFETIME_RESET;
         valid_ff     <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         time_now_ff  <= time_now_in;
         lifetime_ff  <= lifetime_in;
         valid_ff     <= valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      rd_value_ff   <= rd_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.read_value    = rsp_value_ff;
   assign rsp_ch.expired_count = rsp_count_ff;

   // no second acceptance right behind a transaction
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("accepted a transaction while the scan was busy");

   // time only moves on an accepted tick
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (req_ch.action == ACT_TICK)) |=> (time_now_ff == $past(time_now_ff)))
      else $error("time counter moved without a tick");

   // a found result is a plain done with no expiry count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.found) |-> ((rsp_ch.status == ST_DONE)
                                           && (rsp_ch.expired_count == '0)))
      else $error("found result carries a bad status or count");

   // every issued read returns an entry in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && (cnt_ff != cnt_type'(ENTRIES))) |=> rd_vld_ff)
      else $error("scan lost a RAM read");

endmodule

FILE: design/ekvt_ram.sv
`timescale 1ns / 1ps

module ekvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ekvt_cmp.sv
`timescale 1ns / 1ps

// Shared compare unit: key match and wrapped deadline check for one entry.
module ekvt_cmp (
   input  ekvt_pkg::key_type     key_a,
   input  ekvt_pkg::key_type     key_b,
   input  ekvt_pkg::time_type    time_now,
   input  ekvt_pkg::time_type    deadline,
   output ekvt_pkg::cmp_out_type result
);
   import ekvt_pkg::*;

   time_type diff;

   always_comb begin
      diff           = time_now - deadline;
      result.key_eq  = (key_a == key_b);
      // expired when deadline lies strictly behind now, within half the range
      result.expired = (diff != '0) && !diff[TIME_BITS-1];
   end

endmodule
